FILE: rtl/lfn_u2u8_pkg.sv
// Shared types, constants and UTF-8 encoding helpers for the LFN UTF-16 to UTF-8 unit.
// Used by the front, queue, back and top-level modules. No dependencies.
`timescale 1ns / 1ps

package lfn_u2u8_pkg;

    // Code unit classes.
    localparam logic [15:0] UNIT_TERM     = 16'h0000;
    localparam logic [15:0] UNIT_PAD      = 16'hFFFF;
    localparam logic [5:0]  SURR_HIGH_TAG = 6'b110110;
    localparam logic [5:0]  SURR_LOW_TAG  = 6'b110111;
    localparam logic [20:0] SUPP_BASE     = 21'h10000;

    // Code point range limits for the sequence length.
    localparam logic [20:0] CP_MAX_1B = 21'h00007F;
    localparam logic [20:0] CP_MAX_2B = 21'h0007FF;
    localparam logic [20:0] CP_MAX_3B = 21'h00FFFF;

    // Lead and continuation byte prefixes.
    localparam logic [7:0] LEAD_2B = 8'hC0;
    localparam logic [7:0] LEAD_3B = 8'hE0;
    localparam logic [7:0] LEAD_4B = 8'hF0;
    localparam logic [7:0] CONT_B  = 8'h80;

    // One queued item: up to two code points, emitted in order.
    typedef struct packed {
        logic [20:0] cp0;
        logic        v0;
        logic [20:0] cp1;
        logic        v1;
    } u2u8_entry_t;

    // Number of UTF-8 bytes for a code point (1 to 4).
    function automatic logic [2:0] utf8_len(input logic [20:0] cp);
        logic [2:0] len;
        if (cp <= CP_MAX_1B) begin
            len = 3'd1;
        end else if (cp <= CP_MAX_2B) begin
            len = 3'd2;
        end else if (cp <= CP_MAX_3B) begin
            len = 3'd3;
        end else begin
            len = 3'd4;
        end
        return len;
    endfunction

    // Byte number idx of the UTF-8 sequence of cp, given its length.
    function automatic logic [7:0] utf8_byte(input logic [20:0] cp, input logic [2:0] len,
                                             input logic [1:0] idx);
        logic [7:0] b;
        b = 8'h00;
        unique case (len)
            3'd1: b = {1'b0, cp[6:0]};
            3'd2: begin
                unique case (idx)
                    2'd0:    b = LEAD_2B | {3'b000, cp[10:6]};
                    default: b = CONT_B | {2'b00, cp[5:0]};
                endcase
            end
            3'd3: begin
                unique case (idx)
                    2'd0:    b = LEAD_3B | {4'b0000, cp[15:12]};
                    2'd1:    b = CONT_B | {2'b00, cp[11:6]};
                    default: b = CONT_B | {2'b00, cp[5:0]};
                endcase
            end
            default: begin
                unique case (idx)
                    2'd0:    b = LEAD_4B | {5'b00000, cp[20:18]};
                    2'd1:    b = CONT_B | {2'b00, cp[17:12]};
                    2'd2:    b = CONT_B | {2'b00, cp[11:6]};
                    default: b = CONT_B | {2'b00, cp[5:0]};
                endcase
            end
        endcase
        return b;
    endfunction

endpackage

FILE: rtl/lfn_u2u8_front.sv
// Front part: accepts code units, tracks surrogate and terminator state,
// and pushes up to two code points per unit into the queue. Uses lfn_u2u8_pkg.
`timescale 1ns / 1ps

module lfn_u2u8_front (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [15:0]               s_tdata,
    input  logic                      s_tlast,
    output logic                      push_valid,
    input  logic                      push_ready,
    output lfn_u2u8_pkg::u2u8_entry_t push_entry
);

    logic [9:0] held_bits_reg, held_bits_next;
    logic       held_valid_reg, held_valid_next;
    logic       term_reg, term_next;
    logic       accept;
    logic       is_high, is_low;
    logic [20:0] flush_cp;
    lfn_u2u8_pkg::u2u8_entry_t entry;

    assign s_tready = push_ready;
    assign accept   = s_tvalid && s_tready;

    assign is_high  = (s_tdata[15:10] == lfn_u2u8_pkg::SURR_HIGH_TAG);
    assign is_low   = (s_tdata[15:10] == lfn_u2u8_pkg::SURR_LOW_TAG);
    assign flush_cp = {5'b00000, lfn_u2u8_pkg::SURR_HIGH_TAG, held_bits_reg};

    // Classify the unit and work out the code points it releases.
    always_comb begin
        entry           = '0;
        held_bits_next  = held_bits_reg;
        held_valid_next = held_valid_reg;
        term_next       = term_reg;
        if (!term_reg) begin
            priority if (s_tdata == lfn_u2u8_pkg::UNIT_TERM) begin
                entry.v0        = held_valid_reg;
                entry.cp0       = flush_cp;
                held_valid_next = 1'b0;
                term_next       = 1'b1;
            end else if (s_tdata == lfn_u2u8_pkg::UNIT_PAD) begin
                // Padding leaves a pending pair untouched.
            end else if (is_high) begin
                entry.v0        = held_valid_reg;
                entry.cp0       = flush_cp;
                held_bits_next  = s_tdata[9:0];
                held_valid_next = 1'b1;
            end else if (is_low) begin
                entry.v0 = 1'b1;
                if (held_valid_reg) begin
                    entry.cp0       = lfn_u2u8_pkg::SUPP_BASE
                                      + {1'b0, held_bits_reg, s_tdata[9:0]};
                    held_valid_next = 1'b0;
                end else begin
                    entry.cp0 = {5'b00000, s_tdata};
                end
            end else begin
                entry.v0        = held_valid_reg;
                entry.cp0       = flush_cp;
                held_valid_next = 1'b0;
                entry.cp1       = {5'b00000, s_tdata};
                entry.v1        = 1'b1;
            end
        end
        // Fragment end flushes what is still held and clears the state.
        if (s_tlast) begin
            if (held_valid_next) begin
                entry.v1  = 1'b1;
                entry.cp1 = {5'b00000, lfn_u2u8_pkg::SURR_HIGH_TAG, held_bits_next};
            end
            held_valid_next = 1'b0;
            held_bits_next  = '0;
            term_next       = 1'b0;
        end
    end

    assign push_valid = accept && (entry.v0 || entry.v1);
    assign push_entry = entry;

    // State registers update on every accepted beat.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_bits_reg  <= '0;
            held_valid_reg <= 1'b0;
            term_reg       <= 1'b0;
        end else if (accept) begin
            held_bits_reg  <= held_bits_next;
            held_valid_reg <= held_valid_next;
            term_reg       <= term_next;
        end
    end

endmodule

FILE: rtl/lfn_u2u8_fifo.sv
// Short queue of code point entries between the front and back parts.
// Uses lfn_u2u8_pkg for the entry type.
`timescale 1ns / 1ps

module lfn_u2u8_fifo #(
    parameter int DEPTH = 4
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      push_valid,
    output logic                      push_ready,
    input  lfn_u2u8_pkg::u2u8_entry_t push_entry,
    output logic                      pop_valid,
    input  logic                      pop_ready,
    output lfn_u2u8_pkg::u2u8_entry_t pop_entry
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

    lfn_u2u8_pkg::u2u8_entry_t slot_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] count_reg;
    logic          do_push, do_pop;

    assign push_ready = (count_reg != CNT_FULL);
    assign pop_valid  = (count_reg != '0);
    assign pop_entry  = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Entry storage.
    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

FILE: rtl/lfn_u2u8_back.sv
// Back part: takes queued code points and sends their UTF-8 bytes one beat
// at a time through a registered output stage. Uses lfn_u2u8_pkg.
`timescale 1ns / 1ps

module lfn_u2u8_back (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      pop_valid,
    output logic                      pop_ready,
    input  lfn_u2u8_pkg::u2u8_entry_t pop_entry,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [7:0]                m_tdata,
    output logic                      m_tlast
);

    logic [20:0] cp0_reg, cp1_reg;
    logic        v1_reg;
    logic        phase_reg;
    logic [1:0]  idx_reg;
    logic        active_reg;
    logic        m_tvalid_reg;
    logic [7:0]  m_tdata_reg;
    logic        m_tlast_reg;

    logic        out_free, emit, seq_done, item_done;
    logic [20:0] cur_cp;
    logic [2:0]  cur_len;

    assign out_free  = !m_tvalid_reg || m_tready;
    assign emit      = active_reg && out_free;
    assign cur_cp    = phase_reg ? cp1_reg : cp0_reg;
    assign cur_len   = lfn_u2u8_pkg::utf8_len(cur_cp);
    assign seq_done  = ({1'b0, idx_reg} == (cur_len - 3'd1));
    assign item_done = seq_done && (phase_reg || !v1_reg);
    assign pop_ready = !active_reg || (emit && item_done);

    // Sequencer over the one or two code points of an entry.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= 1'b0;
            phase_reg  <= 1'b0;
            idx_reg    <= '0;
        end else if (pop_valid && pop_ready) begin
            active_reg <= 1'b1;
            phase_reg  <= !pop_entry.v0;
            idx_reg    <= '0;
        end else if (emit) begin
            if (item_done) begin
                active_reg <= 1'b0;
            end else if (seq_done) begin
                phase_reg <= 1'b1;
                idx_reg   <= '0;
            end else begin
                idx_reg <= idx_reg + 2'd1;
            end
        end
    end

    // Code points of the entry being sent.
    always_ff @(posedge aclk) begin
        if (pop_valid && pop_ready) begin
            cp0_reg <= pop_entry.cp0;
            cp1_reg <= pop_entry.cp1;
            v1_reg  <= pop_entry.v1;
        end
    end

    // Output register: loads a new byte whenever it is empty or being taken.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_free) begin
            m_tvalid_reg <= emit;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            m_tdata_reg <= lfn_u2u8_pkg::utf8_byte(cur_cp, cur_len, idx_reg);
            m_tlast_reg <= item_done;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

FILE: rtl/lfn_u2u8_unit.sv
// Top level of the long-file-name UTF-16 to UTF-8 converter.
// Instantiates lfn_u2u8_front, lfn_u2u8_fifo and lfn_u2u8_back; uses lfn_u2u8_pkg.
//
//   Channel | Dir | tdata (low bit up) | tlast          | Beat
//   s_      | in  | code_unit[15:0]    | fragment_end   | one UTF-16 code unit
//   m_      | out | utf8_byte[7:0]     | last_of_run    | one UTF-8 byte
//
// The front takes one code unit per cycle while the queue has room; the back
// sends one byte per cycle while m_tready is high, and each code unit yields
// 0 to 6 bytes (typically 1 for ASCII names). The back's byte sequencer sets
// the sustained rate.
// Reset (aresetn low, synchronous) clears the surrogate/terminator state, the
// queue and the output register. Either side may stall without blocking the other
// until the queue of FIFO_DEPTH entries fills.
`timescale 1ns / 1ps

module lfn_utf16_to_utf8_unit #(
    parameter int FIFO_DEPTH = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] code_unit
    input  logic        s_tlast,   // fragment_end
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] utf8_byte
    output logic        m_tlast    // last_of_run
);

    logic                      push_valid, push_ready;
    logic                      pop_valid, pop_ready;
    lfn_u2u8_pkg::u2u8_entry_t push_entry, pop_entry;

    lfn_u2u8_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry)
    );

    lfn_u2u8_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_entry  (pop_entry)
    );

    lfn_u2u8_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_entry (pop_entry),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule
